// ===== sv/lsug_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsug_pkg
// Shared types, constants and helpers for the level-set upwind gradient and
// normal pipeline.
// ----------------------------------------------------------------------------
package lsug_pkg;

   // Register map of the configuration port
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_INV = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_INV = 1'b1;
   localparam logic [31:0] INV_RESET = 32'h0001_0000;

   // Fixed widths of the datapath
   localparam int unsigned MAG_W      = 32;  // saturated difference magnitude
   localparam int unsigned NORM_W     = 31;  // normalized pair member
   localparam int unsigned LEAD_IN_W  = 33;  // input of the leading-one search
   localparam int unsigned POS_W      = 6;
   localparam int unsigned RAD_W      = 64;
   localparam int unsigned ROOT_W     = 32;
   localparam int unsigned TERM_QUO_W = 31;  // Q1.30 term quotient
   localparam int unsigned TERM_NUM_W = 61;
   localparam int unsigned UNIT_QUO_W = 15;  // Q1.14 component quotient
   localparam int unsigned UNIT_NUM_W = 45;
   localparam int unsigned SUM_W      = 34;  // signed sum of four terms
   localparam int unsigned NORMAL_W   = 16;

   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic zero;
   } term_meta_type;

   typedef struct packed {
      logic [ROOT_W-1:0] plus;
      logic [ROOT_W-1:0] minus;
   } grads_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero_x;
      logic zero_y;
   } unit_meta_type;

   // Sideband through the first root unit
   typedef struct packed {
      logic [3:0][NORM_W-1:0] ua;
      logic [3:0][NORM_W-1:0] ub;
      term_meta_type [3:0]    meta;
   } sqa_pay_type;

   // Sideband through the term dividers
   typedef struct packed {
      grads_type          grads;
      term_meta_type [3:0] meta;
   } divb_pay_type;

   // Sideband through the final root unit
   typedef struct packed {
      grads_type         grads;
      logic [NORM_W-1:0] us;
      logic [NORM_W-1:0] uo;
      unit_meta_type     meta;
   } sqc_pay_type;

   // Sideband through the component dividers
   typedef struct packed {
      grads_type     grads;
      unit_meta_type meta;
   } divd_pay_type;

   // Bit index of the leading one
   function automatic logic [POS_W-1:0] lead_pos(input logic [LEAD_IN_W-1:0] v);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < LEAD_IN_W; i++) begin
         if (v[i]) begin
            pos = POS_W'(i);
         end
      end
      return pos;
   endfunction

   // Shift so that a leading one at pos lands on bit 30; low bits drop
   function automatic logic [NORM_W-1:0] norm_shift(input logic [LEAD_IN_W-1:0] v,
                                                   input logic [POS_W-1:0] pos);
      logic [63:0] t;
      t = 64'(v);
      if (pos > POS_W'(30)) begin
         t = t >> (pos - POS_W'(30));
      end else begin
         t = t << (POS_W'(30) - pos);
      end
      return t[NORM_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/lsug_sqrt_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsug_sqrt_pipe
// Pipelined floor square root, one root bit per stage, several lanes in
// lockstep with a sideband that rides along.
// ----------------------------------------------------------------------------
module lsug_sqrt_pipe #(
   parameter int LANES = 1,
   parameter int RAD_W = 64,
   parameter int PAY_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [LANES-1:0][RAD_W-1:0]          in_rad,
   input  logic [PAY_W-1:0]                     in_pay,
   output logic                                 out_valid,
   output logic [LANES-1:0][RAD_W/2-1:0]        out_root,
   output logic [PAY_W-1:0]                     out_pay
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int STEPS  = ROOT_W;

   logic [STEPS-1:0]                  vld_ff;
   logic [STEPS-1:0]                  vld_in;
   logic [LANES-1:0][REM_W-1:0]       rem_ff  [STEPS];
   logic [LANES-1:0][REM_W-1:0]       rem_in  [STEPS];
   logic [LANES-1:0][ROOT_W-1:0]      root_ff [STEPS];
   logic [LANES-1:0][ROOT_W-1:0]      root_in [STEPS];
   logic [LANES-1:0][RAD_W-1:0]       rad_ff  [STEPS];
   logic [LANES-1:0][RAD_W-1:0]       rad_in  [STEPS];
   logic [PAY_W-1:0]                  pay_ff  [STEPS];
   logic [PAY_W-1:0]                  pay_in  [STEPS];

   // One root bit per stage: bring down two radicand bits, try 4r+1
   always_comb begin
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W+1:0]  sh;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      for (int s = 0; s < STEPS; s++) begin
         vld_in[s] = (s == 0) ? in_valid : vld_ff[s-1];
         pay_in[s] = (s == 0) ? in_pay : pay_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            src_rem  = (s == 0) ? '0 : rem_ff[s-1][l];
            src_root = (s == 0) ? '0 : root_ff[s-1][l];
            src_rad  = (s == 0) ? in_rad[l] : rad_ff[s-1][l];
            sh       = {src_rem, src_rad[RAD_W-1 -: 2]};
            trial    = {2'b00, src_root, 2'b01};
            diff     = sh - trial;
            if (sh >= trial) begin
               rem_in[s][l]  = diff[REM_W-1:0];
               root_in[s][l] = {src_root[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in[s][l]  = sh[REM_W-1:0];
               root_in[s][l] = {src_root[ROOT_W-2:0], 1'b0};
            end
            rad_in[s][l] = src_rad << 2;
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         pay_ff  <= pay_in;
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

endmodule
`default_nettype wire

// ===== sv/lsug_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsug_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lockstep. The quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module lsug_div_pipe #(
   parameter int LANES = 1,
   parameter int NUM_W = 61,
   parameter int DEN_W = 32,
   parameter int QUO_W = 31,
   parameter int PAY_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [LANES-1:0][DEN_W-1:0]   in_den,
   input  logic [PAY_W-1:0]              in_pay,
   output logic                          out_valid,
   output logic [LANES-1:0][QUO_W-1:0]   out_quo,
   output logic [PAY_W-1:0]              out_pay
);
   localparam int STEPS = QUO_W;

   logic [STEPS-1:0]                vld_ff;
   logic [STEPS-1:0]                vld_in;
   logic [LANES-1:0][DEN_W-1:0]     rem_ff [STEPS];
   logic [LANES-1:0][DEN_W-1:0]     rem_in [STEPS];
   logic [LANES-1:0][QUO_W-1:0]     low_ff [STEPS];
   logic [LANES-1:0][QUO_W-1:0]     low_in [STEPS];
   logic [LANES-1:0][QUO_W-1:0]     quo_ff [STEPS];
   logic [LANES-1:0][QUO_W-1:0]     quo_in [STEPS];
   logic [LANES-1:0][DEN_W-1:0]     den_ff [STEPS];
   logic [LANES-1:0][DEN_W-1:0]     den_in [STEPS];
   logic [PAY_W-1:0]                pay_ff [STEPS];
   logic [PAY_W-1:0]                pay_in [STEPS];

   // One quotient bit per stage: shift in a numerator bit, subtract if it fits
   always_comb begin
      logic [NUM_W-1:0] hi;
      logic [DEN_W-1:0] src_rem;
      logic [QUO_W-1:0] src_low;
      logic [QUO_W-1:0] src_quo;
      logic [DEN_W-1:0] src_den;
      logic [DEN_W:0]   sh;
      logic [DEN_W:0]   diff;
      for (int s = 0; s < STEPS; s++) begin
         vld_in[s] = (s == 0) ? in_valid : vld_ff[s-1];
         pay_in[s] = (s == 0) ? in_pay : pay_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            hi      = in_num[l] >> QUO_W;
            src_rem = (s == 0) ? hi[DEN_W-1:0] : rem_ff[s-1][l];
            src_low = (s == 0) ? in_num[l][QUO_W-1:0] : low_ff[s-1][l];
            src_quo = (s == 0) ? '0 : quo_ff[s-1][l];
            src_den = (s == 0) ? in_den[l] : den_ff[s-1][l];
            sh      = {src_rem, src_low[QUO_W-1]};
            diff    = sh - {1'b0, src_den};
            if (sh >= {1'b0, src_den}) begin
               rem_in[s][l] = diff[DEN_W-1:0];
               quo_in[s][l] = {src_quo[QUO_W-2:0], 1'b1};
            end else begin
               rem_in[s][l] = sh[DEN_W-1:0];
               quo_in[s][l] = {src_quo[QUO_W-2:0], 1'b0};
            end
            low_in[s][l] = src_low << 1;
            den_in[s][l] = src_den;
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Advance data
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         den_ff <= den_in;
         pay_ff <= pay_in;
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_pay   = pay_ff[STEPS-1];

endmodule
`default_nettype wire

// ===== sv/level_set_upwind_gradient_normal_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// level_set_upwind_gradient_normal_top
// Upwind gradient magnitudes and unit front normal of one level-set cell.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   five Q16.16 stencil values
//   rsp      out        rsp_valid / rsp_stall   grad_plus, grad_minus, normal
//   csr      in         csr_write               csr_index, csr_wdata
//
// One request per cycle unless held; the pipeline has 8 difference and square
// stages, a 32-stage root unit, a 31-stage term divider, 6 summing stages, a
// second 32-stage root unit, a 15-stage component divider and the output
// register. The whole pipeline, bubbles included, holds while a result waits
// under rsp_stall. Reset (synchronous) clears all valid bits and sets both
// inverse spacings to 1.0.
// ----------------------------------------------------------------------------
module level_set_upwind_gradient_normal_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [lsug_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [31:0]                            csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [VALUE_WIDTH-1:0]          req_centre_value,
   input  logic signed [VALUE_WIDTH-1:0]          req_west_value,
   input  logic signed [VALUE_WIDTH-1:0]          req_east_value,
   input  logic signed [VALUE_WIDTH-1:0]          req_south_value,
   input  logic signed [VALUE_WIDTH-1:0]          req_north_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [31:0]                            rsp_grad_plus,
   output logic [31:0]                            rsp_grad_minus,
   output logic signed [15:0]                     rsp_normal_x,
   output logic signed [15:0]                     rsp_normal_y
);
   localparam int VW = VALUE_WIDTH;
   localparam int MW = lsug_pkg::MAG_W;
   localparam int NW = lsug_pkg::NORM_W;
   localparam int SW = lsug_pkg::SUM_W;

   // Difference slots: 0 backward x, 1 forward x, 2 backward y, 3 forward y
   localparam logic [3:0] BACKWARD = 4'b0101;
   // Normal terms pair an x difference with a y difference
   localparam logic [1:0] TERM_A [4] = '{2'd1, 2'd0, 2'd1, 2'd0};
   localparam logic [1:0] TERM_B [4] = '{2'd3, 2'd3, 2'd2, 2'd2};

   logic        adv;
   logic [31:0] xinv_ff;
   logic [31:0] yinv_ff;
   logic [7:0]  fv_ff;   // front stage valids
   logic [5:0]  bv_ff;   // summing stage valids

   // Front stages
   logic [4:0][VW-1:0]        val1_ff;
   logic [3:0][VW-1:0]        mag2_ff, mag2_in;
   logic [3:0]                neg2_ff, neg2_in, neg3_ff, neg4_ff, neg5_ff;
   logic [3:0][63:0]          prod3_ff, prod3_in;
   logic [3:0]                big3_ff, big3_in, izero3_ff, izero3_in;
   logic [3:0][MW-1:0]        mag4_ff, mag4_in, mag5_ff;
   logic [3:0][63:0]          sq5_ff, sq5_in;
   logic [3:0][5:0]           pos5_ff, pos5_in;
   logic [3:0]                zero5_ff, zero5_in;
   logic [64:0]               gp01_ff, gp23_ff, gm01_ff, gm23_ff;
   logic [64:0]               gp01_in, gp23_in, gm01_in, gm23_in;
   logic [3:0][NW-1:0]        ua6_ff, ub6_ff, ua6_in, ub6_in, ua7_ff, ub7_ff, ua8_ff, ub8_ff;
   lsug_pkg::term_meta_type [3:0] meta6_ff, meta6_in, meta7_ff, meta8_ff;
   logic [63:0]               gpr7_ff, gmr7_ff, gpr7_in, gmr7_in, gpr8_ff, gmr8_ff;
   logic [3:0][61:0]          sa7_ff, sb7_ff, sa7_in, sb7_in;
   logic [3:0][63:0]          pr8_in, pr8_ff;

   // Root unit A and term dividers
   logic [5:0][63:0]          sqa_rad;
   lsug_pkg::sqa_pay_type     sqa_pay_in, sqa_pay_out;
   logic                      sqa_valid;
   logic [5:0][31:0]          sqa_root;
   logic [7:0][lsug_pkg::TERM_NUM_W-1:0] divb_num;
   logic [7:0][31:0]          divb_den;
   lsug_pkg::divb_pay_type    divb_pay_in, divb_pay_out;
   logic                      divb_valid;
   logic [7:0][lsug_pkg::TERM_QUO_W-1:0] divb_quo;

   // Summing stages
   logic signed [SW-1:0]      sx01_ff, sx23_ff, sy01_ff, sy23_ff;
   logic signed [SW-1:0]      sx01_in, sx23_in, sy01_in, sy23_in;
   logic signed [SW-1:0]      sx2_ff, sy2_ff;
   logic [32:0]               us3_ff, uo3_ff, us3_in, uo3_in;
   logic [5:0]                pos3_ff, pos3_in;
   lsug_pkg::unit_meta_type   fm3_in, fm3_ff, fm4_ff, fm5_ff, fm6_ff;
   logic [NW-1:0]             us4_ff, uo4_ff, us5_ff, uo5_ff, us6_ff, uo6_ff;
   logic [61:0]               ss5_ff, so5_ff, ss5_in, so5_in;
   logic [63:0]               rad6_ff;
   lsug_pkg::grads_type       gr1_ff, gr2_ff, gr3_ff, gr4_ff, gr5_ff, gr6_ff;

   // Root unit C and component dividers
   lsug_pkg::sqc_pay_type     sqc_pay_in, sqc_pay_out;
   logic                      sqc_valid;
   logic [0:0][31:0]          sqc_root;
   logic [1:0][lsug_pkg::UNIT_NUM_W-1:0] divd_num;
   logic [1:0][31:0]          divd_den;
   lsug_pkg::divd_pay_type    divd_pay_in, divd_pay_out;
   logic                      divd_valid;
   logic [1:0][lsug_pkg::UNIT_QUO_W-1:0] divd_quo;

   logic                      rsp_valid_ff;
   logic [31:0]               rsp_gp_ff, rsp_gm_ff;
   logic signed [15:0]        rsp_nx_ff, rsp_ny_ff, rsp_nx_in, rsp_ny_in;

   // Hold every stage while the result register is full and stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xinv_ff <= lsug_pkg::INV_RESET;
         yinv_ff <= lsug_pkg::INV_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lsug_pkg::CSR_X_INV: xinv_ff <= csr_wdata;
            lsug_pkg::CSR_Y_INV: yinv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits of the stages owned here
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff        <= '0;
         bv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         fv_ff        <= {fv_ff[6:0], req_valid};
         bv_ff        <= {bv_ff[4:0], divb_valid};
         rsp_valid_ff <= divd_valid;
      end
   end

   // Differences, magnitudes and products
   always_comb begin
      logic signed [VW:0] diff;
      logic [VW:0]        ndiff;
      logic [63:0]        m64;
      logic [31:0]        inv;
      logic [47:0]        p48;
      for (int k = 0; k < 4; k++) begin
         unique case (k)
            0: diff = {val1_ff[0][VW-1], val1_ff[0]} - {val1_ff[1][VW-1], val1_ff[1]};
            1: diff = {val1_ff[2][VW-1], val1_ff[2]} - {val1_ff[0][VW-1], val1_ff[0]};
            2: diff = {val1_ff[0][VW-1], val1_ff[0]} - {val1_ff[3][VW-1], val1_ff[3]};
            default: diff = {val1_ff[4][VW-1], val1_ff[4]} - {val1_ff[0][VW-1], val1_ff[0]};
         endcase
         ndiff      = -diff;
         neg2_in[k] = diff[VW];
         mag2_in[k] = diff[VW] ? ndiff[VW-1:0] : diff[VW-1:0];

         m64          = 64'(mag2_ff[k]);
         inv          = (k < 2) ? xinv_ff : yinv_ff;
         big3_in[k]   = |m64[63:32];
         izero3_in[k] = (inv == '0);
         prod3_in[k]  = {32'd0, m64[31:0]} * {32'd0, inv};

         p48 = prod3_ff[k][63:16];
         if (izero3_ff[k]) begin
            mag4_in[k] = '0;
         end else if (big3_ff[k] || (|p48[47:32])) begin
            mag4_in[k] = '1;
         end else begin
            mag4_in[k] = p48[31:0];
         end

         sq5_in[k] = {32'd0, mag4_ff[k]} * {32'd0, mag4_ff[k]};
      end
   end

   // Pair search, gradient sums, normalized pairs and their squares
   always_comb begin
      logic [MW-1:0]      both;
      logic [3:0][63:0]   pp, mp;
      logic [65:0]        gsum;
      logic [63:0]        sqa, sqb;
      for (int t = 0; t < 4; t++) begin
         both        = mag4_ff[TERM_A[t]] | mag4_ff[TERM_B[t]];
         pos5_in[t]  = lsug_pkg::lead_pos(33'(both));
         zero5_in[t] = (both == '0);
         ua6_in[t]   = lsug_pkg::norm_shift(33'(mag5_ff[TERM_A[t]]), pos5_ff[t]);
         ub6_in[t]   = lsug_pkg::norm_shift(33'(mag5_ff[TERM_B[t]]), pos5_ff[t]);
         meta6_in[t].neg_a = neg5_ff[TERM_A[t]];
         meta6_in[t].neg_b = neg5_ff[TERM_B[t]];
         meta6_in[t].zero  = zero5_ff[t];
         sqa        = {33'd0, ua6_ff[t]} * {33'd0, ua6_ff[t]};
         sqb        = {33'd0, ub6_ff[t]} * {33'd0, ub6_ff[t]};
         sa7_in[t]  = sqa[61:0];
         sb7_in[t]  = sqb[61:0];
         pr8_in[t]  = {2'b00, sa7_ff[t]} + {2'b00, sb7_ff[t]};
      end
      // A square joins grad_plus when it points upwind for outward motion
      for (int k = 0; k < 4; k++) begin
         if (BACKWARD[k] ^ neg5_ff[k]) begin
            pp[k] = sq5_ff[k];
            mp[k] = '0;
         end else begin
            pp[k] = '0;
            mp[k] = sq5_ff[k];
         end
      end
      gp01_in = {1'b0, pp[0]} + {1'b0, pp[1]};
      gp23_in = {1'b0, pp[2]} + {1'b0, pp[3]};
      gm01_in = {1'b0, mp[0]} + {1'b0, mp[1]};
      gm23_in = {1'b0, mp[2]} + {1'b0, mp[3]};
      // A sum of 2^64 or more becomes all ones, whose root is 0xFFFFFFFF
      gsum    = {1'b0, gp01_ff} + {1'b0, gp23_ff};
      gpr7_in = (|gsum[65:64]) ? '1 : gsum[63:0];
      gsum    = {1'b0, gm01_ff} + {1'b0, gm23_ff};
      gmr7_in = (|gsum[65:64]) ? '1 : gsum[63:0];
   end

   // Front pipeline registers
   always_ff @(posedge clock) begin
      if (adv) begin
         val1_ff   <= {req_north_value, req_south_value, req_east_value,
                       req_west_value, req_centre_value};
         mag2_ff   <= mag2_in;
         neg2_ff   <= neg2_in;
         prod3_ff  <= prod3_in;
         big3_ff   <= big3_in;
         izero3_ff <= izero3_in;
         neg3_ff   <= neg2_ff;
         mag4_ff   <= mag4_in;
         neg4_ff   <= neg3_ff;
         sq5_ff    <= sq5_in;
         pos5_ff   <= pos5_in;
         zero5_ff  <= zero5_in;
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
         gp01_ff   <= gp01_in;
         gp23_ff   <= gp23_in;
         gm01_ff   <= gm01_in;
         gm23_ff   <= gm23_in;
         ua6_ff    <= ua6_in;
         ub6_ff    <= ub6_in;
         meta6_ff  <= meta6_in;
         gpr7_ff   <= gpr7_in;
         gmr7_ff   <= gmr7_in;
         sa7_ff    <= sa7_in;
         sb7_ff    <= sb7_in;
         ua7_ff    <= ua6_ff;
         ub7_ff    <= ub6_ff;
         meta7_ff  <= meta6_ff;
         gpr8_ff   <= gpr7_ff;
         gmr8_ff   <= gmr7_ff;
         pr8_ff    <= pr8_in;
         ua8_ff    <= ua7_ff;
         ub8_ff    <= ub7_ff;
         meta8_ff  <= meta7_ff;
      end
   end

   // Gradient roots and pair radii
   assign sqa_rad         = {pr8_ff[3], pr8_ff[2], pr8_ff[1], pr8_ff[0], gmr8_ff, gpr8_ff};
   assign sqa_pay_in.ua   = ua8_ff;
   assign sqa_pay_in.ub   = ub8_ff;
   assign sqa_pay_in.meta = meta8_ff;

   lsug_sqrt_pipe #(
      .LANES (6),
      .RAD_W (lsug_pkg::RAD_W),
      .PAY_W ($bits(lsug_pkg::sqa_pay_type))
   ) u_sqrt_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (fv_ff[7]),
      .in_rad    (sqa_rad),
      .in_pay    (sqa_pay_in),
      .out_valid (sqa_valid),
      .out_root  (sqa_root),
      .out_pay   (sqa_pay_out)
   );

   // Term quotients: x parts in lanes 0-3, y parts in lanes 4-7
   always_comb begin
      for (int t = 0; t < 4; t++) begin
         divb_num[t]     = {sqa_pay_out.ua[t], 30'd0};
         divb_num[t + 4] = {sqa_pay_out.ub[t], 30'd0};
         divb_den[t]     = sqa_root[t + 2];
         divb_den[t + 4] = sqa_root[t + 2];
      end
   end
   assign divb_pay_in.grads.plus  = sqa_root[0];
   assign divb_pay_in.grads.minus = sqa_root[1];
   assign divb_pay_in.meta        = sqa_pay_out.meta;

   lsug_div_pipe #(
      .LANES (8),
      .NUM_W (lsug_pkg::TERM_NUM_W),
      .DEN_W (lsug_pkg::ROOT_W),
      .QUO_W (lsug_pkg::TERM_QUO_W),
      .PAY_W ($bits(lsug_pkg::divb_pay_type))
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (sqa_valid),
      .in_num    (divb_num),
      .in_den    (divb_den),
      .in_pay    (divb_pay_in),
      .out_valid (divb_valid),
      .out_quo   (divb_quo),
      .out_pay   (divb_pay_out)
   );

   // Signed terms, sums, magnitudes and the final normalization
   always_comb begin
      logic signed [SW-1:0] tx [4];
      logic signed [SW-1:0] ty [4];
      logic [SW-1:0]        nsx, nsy;
      logic [63:0]          sqs, sqo;
      for (int t = 0; t < 4; t++) begin
         if (divb_pay_out.meta[t].zero) begin
            tx[t] = '0;
            ty[t] = '0;
         end else begin
            tx[t] = divb_pay_out.meta[t].neg_a ? -$signed({3'b000, divb_quo[t]})
                                               :  $signed({3'b000, divb_quo[t]});
            ty[t] = divb_pay_out.meta[t].neg_b ? -$signed({3'b000, divb_quo[t + 4]})
                                               :  $signed({3'b000, divb_quo[t + 4]});
         end
      end
      sx01_in = tx[0] + tx[1];
      sx23_in = tx[2] + tx[3];
      sy01_in = ty[0] + ty[1];
      sy23_in = ty[2] + ty[3];

      nsx           = -sx2_ff;
      nsy           = -sy2_ff;
      us3_in        = sx2_ff[SW-1] ? nsx[32:0] : sx2_ff[32:0];
      uo3_in        = sy2_ff[SW-1] ? nsy[32:0] : sy2_ff[32:0];
      pos3_in       = lsug_pkg::lead_pos(us3_in | uo3_in);
      fm3_in.neg_x  = sx2_ff[SW-1];
      fm3_in.neg_y  = sy2_ff[SW-1];
      fm3_in.zero_x = (sx2_ff == '0);
      fm3_in.zero_y = (sy2_ff == '0);

      sqs    = {33'd0, us4_ff} * {33'd0, us4_ff};
      sqo    = {33'd0, uo4_ff} * {33'd0, uo4_ff};
      ss5_in = sqs[61:0];
      so5_in = sqo[61:0];
   end

   // Summing pipeline registers
   always_ff @(posedge clock) begin
      if (adv) begin
         sx01_ff <= sx01_in;
         sx23_ff <= sx23_in;
         sy01_ff <= sy01_in;
         sy23_ff <= sy23_in;
         gr1_ff  <= divb_pay_out.grads;
         sx2_ff  <= sx01_ff + sx23_ff;
         sy2_ff  <= sy01_ff + sy23_ff;
         gr2_ff  <= gr1_ff;
         us3_ff  <= us3_in;
         uo3_ff  <= uo3_in;
         pos3_ff <= pos3_in;
         fm3_ff  <= fm3_in;
         gr3_ff  <= gr2_ff;
         us4_ff  <= lsug_pkg::norm_shift(us3_ff, pos3_ff);
         uo4_ff  <= lsug_pkg::norm_shift(uo3_ff, pos3_ff);
         fm4_ff  <= fm3_ff;
         gr4_ff  <= gr3_ff;
         ss5_ff  <= ss5_in;
         so5_ff  <= so5_in;
         us5_ff  <= us4_ff;
         uo5_ff  <= uo4_ff;
         fm5_ff  <= fm4_ff;
         gr5_ff  <= gr4_ff;
         rad6_ff <= {2'b00, ss5_ff} + {2'b00, so5_ff};
         us6_ff  <= us5_ff;
         uo6_ff  <= uo5_ff;
         fm6_ff  <= fm5_ff;
         gr6_ff  <= gr5_ff;
      end
   end

   // Radius of the summed normal
   assign sqc_pay_in.grads = gr6_ff;
   assign sqc_pay_in.us    = us6_ff;
   assign sqc_pay_in.uo    = uo6_ff;
   assign sqc_pay_in.meta  = fm6_ff;

   lsug_sqrt_pipe #(
      .LANES (1),
      .RAD_W (lsug_pkg::RAD_W),
      .PAY_W ($bits(lsug_pkg::sqc_pay_type))
   ) u_sqrt_c (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (bv_ff[5]),
      .in_rad    (rad6_ff),
      .in_pay    (sqc_pay_in),
      .out_valid (sqc_valid),
      .out_root  (sqc_root),
      .out_pay   (sqc_pay_out)
   );

   // Component quotients
   assign divd_num[0]       = {sqc_pay_out.us, 14'd0};
   assign divd_num[1]       = {sqc_pay_out.uo, 14'd0};
   assign divd_den[0]       = sqc_root[0];
   assign divd_den[1]       = sqc_root[0];
   assign divd_pay_in.grads = sqc_pay_out.grads;
   assign divd_pay_in.meta  = sqc_pay_out.meta;

   lsug_div_pipe #(
      .LANES (2),
      .NUM_W (lsug_pkg::UNIT_NUM_W),
      .DEN_W (lsug_pkg::ROOT_W),
      .QUO_W (lsug_pkg::UNIT_QUO_W),
      .PAY_W ($bits(lsug_pkg::divd_pay_type))
   ) u_div_d (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv),
      .in_valid  (sqc_valid),
      .in_num    (divd_num),
      .in_den    (divd_den),
      .in_pay    (divd_pay_in),
      .out_valid (divd_valid),
      .out_quo   (divd_quo),
      .out_pay   (divd_pay_out)
   );

   // Apply signs; a zero sum gives a zero component
   always_comb begin
      if (divd_pay_out.meta.zero_x) begin
         rsp_nx_in = '0;
      end else begin
         rsp_nx_in = divd_pay_out.meta.neg_x ? -$signed({1'b0, divd_quo[0]})
                                             :  $signed({1'b0, divd_quo[0]});
      end
      if (divd_pay_out.meta.zero_y) begin
         rsp_ny_in = '0;
      end else begin
         rsp_ny_in = divd_pay_out.meta.neg_y ? -$signed({1'b0, divd_quo[1]})
                                             :  $signed({1'b0, divd_quo[1]});
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_gp_ff <= divd_pay_out.grads.plus;
         rsp_gm_ff <= divd_pay_out.grads.minus;
         rsp_nx_ff <= rsp_nx_in;
         rsp_ny_ff <= rsp_ny_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grad_plus  = rsp_gp_ff;
   assign rsp_grad_minus = rsp_gm_ff;
   assign rsp_normal_x   = rsp_nx_ff;
   assign rsp_normal_y   = rsp_ny_ff;

   // Checks
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_stages: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(fv_ff) && $stable(bv_ff))
      else $error("pipeline moved while held");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= 16384 && rsp_normal_x >= -16384 &&
                    rsp_normal_y <= 16384 && rsp_normal_y >= -16384)
      else $error("normal component out of unit range");

endmodule
`default_nettype wire

// ===== sim/level_set_upwind_gradient_normal_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_set_upwind_gradient_normal_top_test
// Self-checking bench for the upwind gradient and front normal pipeline.
// A directed stencil table is walked first, then random stencils over several
// inverse-spacing settings. Each result is checked in order against its typed
// row or a local fixed-point model of the cell, with random idling both sides.
// ----------------------------------------------------------------------------
module level_set_upwind_gradient_normal_top_test;

   localparam int VW         = 32;
   localparam int DRAIN      = 150;
   localparam int STALL_MAX  = 5000;
   localparam int RAND_ITEMS = 2000;
   localparam int PHASES     = 8;

   typedef struct packed {
      logic [31:0]        grad_plus;
      logic [31:0]        grad_minus;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
   } cell_out_t;

   typedef struct {
      logic [VW-1:0] c, w, e, s, n;
      bit            typed;
      cell_out_t     want;
   } stencil_row_t;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write = 1'b0;
   logic [lsug_pkg::CSR_IDX_W-1:0] csr_index = lsug_pkg::CSR_X_INV;
   logic [31:0]                    csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [VW-1:0]           req_centre_value = '0;
   logic signed [VW-1:0]           req_west_value = '0;
   logic signed [VW-1:0]           req_east_value = '0;
   logic signed [VW-1:0]           req_south_value = '0;
   logic signed [VW-1:0]           req_north_value = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [31:0]                    rsp_grad_plus;
   logic [31:0]                    rsp_grad_minus;
   logic signed [15:0]             rsp_normal_x;
   logic signed [15:0]             rsp_normal_y;

   cell_out_t   pending_cells[$];
   logic [31:0] x_inv = lsug_pkg::INV_RESET;
   logic [31:0] y_inv = lsug_pkg::INV_RESET;
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   int          rsp_burst = 0;
   bit          rsp_hold = 1'b0;

   logic [31:0] phase_x[PHASES] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000,
                                    32'h0000_8000, 32'h0010_0000, 32'h0000_0100,
                                    32'h0001_0000};
   logic [31:0] phase_y[PHASES] = '{32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'd0,
                                    32'h0003_0000, 32'h0000_0400, 32'h0000_0100,
                                    32'h0001_0000};

   level_set_upwind_gradient_normal_top #(.VALUE_WIDTH(VW)) u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_centre_value(req_centre_value), .req_west_value(req_west_value),
      .req_east_value(req_east_value), .req_south_value(req_south_value),
      .req_north_value(req_north_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_grad_plus(rsp_grad_plus), .rsp_grad_minus(rsp_grad_minus),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y)
   );

   always #1 clock = ~clock;

   // ---------------- cell model ----------------

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint scaled_diff(input longint d, input logic [31:0] inv);
      logic [63:0] m;
      logic [63:0] p;
      m = (d < 0) ? -d : d;
      if (inv == 0 || m == 0) return 0;
      p = (m * {32'd0, inv}) >> 16;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      return (d < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [63:0] mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [63:0] pos_part(input longint v);
      return (v > 0) ? v : 0;
   endfunction

   function automatic logic [63:0] neg_part(input longint v);
      return (v < 0) ? -v : 0;
   endfunction

   function automatic logic [31:0] upwind_mag(input logic [63:0] a, b, c, d);
      logic [65:0] sum;
      sum = 66'(a * a) + 66'(b * b) + 66'(c * c) + 66'(d * d);
      if (sum[65:64] != 0) return 32'hFFFF_FFFF;
      return 32'(floor_root(sum[63:0]));
   endfunction

   // Shift a pair so the larger member lands in [2^30, 2^31)
   function automatic void fit_pair(inout logic [63:0] a, inout logic [63:0] b);
      logic [63:0] m;
      m = (a > b) ? a : b;
      while (m >= (64'd1 << 31)) begin
         a = a >> 1; b = b >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
         a = a << 1; b = b << 1; m = m << 1;
      end
   endfunction

   function automatic void add_dir(input longint a, input longint b,
                                   inout longint sx, inout longint sy);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] r;
      ua = mag(a);
      ub = mag(b);
      if (ua == 0 && ub == 0) return;
      fit_pair(ua, ub);
      r = floor_root(ua * ua + ub * ub);
      sx += (a < 0) ? -longint'((ua << 30) / r) : longint'((ua << 30) / r);
      sy += (b < 0) ? -longint'((ub << 30) / r) : longint'((ub << 30) / r);
   endfunction

   function automatic logic signed [15:0] unit_part(input longint s, input longint o);
      logic [63:0] us;
      logic [63:0] uo;
      logic [63:0] q;
      if (s == 0) return '0;
      us = mag(s);
      uo = mag(o);
      fit_pair(us, uo);
      q = (us << 14) / floor_root(us * us + uo * uo);
      return (s < 0) ? -16'(q) : 16'(q);
   endfunction

   function automatic cell_out_t cell_gradient_normal(input logic signed [VW-1:0] c, w,
                                                      e, s, n);
      longint    dmx, dpx, dmy, dpy, sx, sy;
      cell_out_t o;
      dmx = scaled_diff(longint'(c) - longint'(w), x_inv);
      dpx = scaled_diff(longint'(e) - longint'(c), x_inv);
      dmy = scaled_diff(longint'(c) - longint'(s), y_inv);
      dpy = scaled_diff(longint'(n) - longint'(c), y_inv);
      o.grad_plus  = upwind_mag(pos_part(dmx), neg_part(dpx), pos_part(dmy), neg_part(dpy));
      o.grad_minus = upwind_mag(pos_part(dpx), neg_part(dmx), pos_part(dpy), neg_part(dmy));
      sx = 0;
      sy = 0;
      add_dir(dpx, dpy, sx, sy);
      add_dir(dmx, dpy, sx, sy);
      add_dir(dpx, dmy, sx, sy);
      add_dir(dmx, dmy, sx, sy);
      o.normal_x = unit_part(sx, sy);
      o.normal_y = unit_part(sy, sx);
      return o;
   endfunction

   // Append one expectation to the scoreboard
   function automatic void expect_cell(input cell_out_t c);
      pending_cells = {pending_cells, c};
   endfunction

   // ---------------- result side ----------------

   // Random stall bursts, none in the calm tail
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_burst == 0) begin
            rsp_hold  = ($urandom_range(0, 3) == 0);
            rsp_burst = $urandom_range(1, 14);
         end
         rsp_burst = rsp_burst - 1;
         rsp_stall <= rsp_hold;
      end
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      cell_out_t got;
      cell_out_t want;
      if (rsp_valid && !rsp_stall && !reset) begin
         got = '{rsp_grad_plus, rsp_grad_minus, rsp_normal_x, rsp_normal_y};
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_cells.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp gp=%h gm=%h nx=%0d ny=%0d got gp=%h gm=%h nx=%0d ny=%0d",
                           want.grad_plus, want.grad_minus, want.normal_x, want.normal_y,
                           got.grad_plus, got.grad_minus, got.normal_x, got.normal_y);
            end
         end
      end
   end

   // Watchdog over cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- request side ----------------

   // Write one register, then leave the port idle before returning
   task automatic csr_put(input logic [lsug_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == lsug_pkg::CSR_X_INV) x_inv = v;
      else y_inv = v;
      @(posedge clock);
   endtask

   task automatic drain_wait();
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Present one request, hold until taken, then maybe idle
   task automatic send_cell(input stencil_row_t row);
      int gap;
      req_valid        <= 1'b1;
      req_centre_value <= row.c;
      req_west_value   <= row.w;
      req_east_value   <= row.e;
      req_south_value  <= row.s;
      req_north_value  <= row.n;
      do @(posedge clock); while (req_stall);
      if (row.typed) expect_cell(row.want);
      else expect_cell(cell_gradient_normal(row.c, row.w, row.e, row.s, row.n));
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_inv();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 32'h0004_0000);
         1: return $urandom_range(32'h0000_4000, 32'h0001_0000);
         2: return $urandom;
         default: return 32'h0001_0000 << $urandom_range(0, 15);
      endcase
   endfunction

   function automatic stencil_row_t rand_row();
      stencil_row_t r;
      logic [VW-1:0] base;
      int sh;
      r.typed = 1'b0;
      r.want  = '0;
      base    = $urandom;
      sh      = $urandom_range(4, 31);
      case ($urandom_range(0, 9))
         0, 1: begin
            r.c = $urandom; r.w = $urandom; r.e = $urandom;
            r.s = $urandom; r.n = $urandom;
         end
         2: begin
            // flat along one axis
            r.c = base; r.w = base; r.e = base;
            r.s = base + ($urandom >> sh); r.n = base - ($urandom >> sh);
         end
         default: begin
            // smooth neighbourhood with random slope
            r.c = base;
            r.w = base + (($urandom >> sh) ^ {VW{$urandom_range(0, 1) == 1}});
            r.e = base + (($urandom >> sh) ^ {VW{$urandom_range(0, 1) == 1}});
            r.s = base + (($urandom >> sh) ^ {VW{$urandom_range(0, 1) == 1}});
            r.n = base + (($urandom >> sh) ^ {VW{$urandom_range(0, 1) == 1}});
         end
      endcase
      return r;
   endfunction

   stencil_row_t directed[$];

   function automatic stencil_row_t mk(input logic [VW-1:0] c, w, e, s, n,
                                       input bit typed = 0,
                                       input cell_out_t want = '0);
      stencil_row_t r;
      r.c = c; r.w = w; r.e = e; r.s = s; r.n = n;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   // Append one row to the directed stimulus
   function automatic void row_add(input stencil_row_t r);
      directed = {directed, r};
   endfunction

   initial begin
      stencil_row_t row;
      int per_phase;

      // Typed rows hold for the reset spacing of 1.0
      row_add(mk(0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}));
      row_add(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 1, '{32'hFFFF_FFFF, 0, 0, 0}));
      row_add(mk(32'h0001_0000, 0, 0, 0, 0, 1, '{32'h0002_0000, 0, 0, 0}));
      row_add(mk(0, 0, 32'h0001_0000, 0, 0, 1, '{0, 32'h0001_0000, 16384, 0}));
      row_add(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF));
      row_add(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF));
      row_add(mk(0, 32'h0001_0000, 0, 0, 0));
      row_add(mk(0, 0, 0, 32'h0001_0000, 0));
      row_add(mk(0, 0, 0, 0, 32'h0001_0000));
      row_add(mk(0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000));
      row_add(mk(0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003));
      row_add(mk(32'h1234_5678, 32'h1230_0000, 32'h1240_0000, 32'h1234_0000,
                 32'h1235_0000));
      row_add(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000));
      row_add(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the table at reset spacing
      foreach (directed[i]) send_cell(directed[i]);
      req_valid <= 1'b0;

      per_phase = RAND_ITEMS / (PHASES + 2);
      for (int p = 0; p < PHASES + 2; p++) begin
         drain_wait();
         if (p < PHASES) begin
            csr_put(lsug_pkg::CSR_X_INV, phase_x[p]);
            csr_put(lsug_pkg::CSR_Y_INV, phase_y[p]);
         end else begin
            csr_put(lsug_pkg::CSR_X_INV, rand_inv());
            csr_put(lsug_pkg::CSR_Y_INV, rand_inv());
         end
         // Replay the table on the extreme settings
         if (p < 4) foreach (directed[i]) begin
            row = directed[i];
            row.typed = 1'b0;
            send_cell(row);
         end
         for (int k = 0; k < per_phase; k++) begin
            if (p == PHASES + 1 && k > per_phase / 2) calm = 1'b1;
            send_cell(rand_row());
         end
         req_valid <= 1'b0;
      end

      drain_wait();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
